FILE: src/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check, disabled while reset is high.
`define FWHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define FWHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/fwht_pkg.sv
// Package with types, constants and helpers of the Walsh-Hadamard transform unit.
package fwht_pkg;
  localparam int LOG2_MAX_LEN = 6;
  localparam int MAX_LEN = 1 << LOG2_MAX_LEN;
  localparam int WORD_W = 30;
  localparam int SAMPLE_W = 24;
  localparam int CNT_W = LOG2_MAX_LEN + 1;
  localparam int LOG_W = 3;
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_SIZE_LOG2 = 2'd0;
  localparam logic [1:0] REG_DIRECTION = 2'd1;
  localparam logic [1:0] REG_OUTPUT_ORDER = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_BFLY  = 3'd2,
    OP_PERM  = 3'd3,
    OP_SHIFT = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     inverse;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_STAGE = 4'b0010,
    ST_PERM  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  function automatic int bit_rev(input int v, input int bits);
    int r;
    r = 0;
    for (int k = 0; k < bits; k++) begin
      r = (r << 1) | ((v >> k) & 1);
    end
    return r;
  endfunction
endpackage

FILE: src/fwht_in_if.sv
// Sample input channel.
interface fwht_in_if;
  logic valid;
  logic ready;
  logic signed [fwht_pkg::SAMPLE_W-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

FILE: src/fwht_out_if.sv
// Coefficient output channel.
interface fwht_out_if;
  logic valid;
  logic ready;
  logic signed [fwht_pkg::WORD_W-1:0] coefficient;
  logic [fwht_pkg::LOG2_MAX_LEN-1:0] out_index;
  logic last_of_block;
  modport source (output valid, output coefficient, output out_index,
                  output last_of_block, input ready);
  modport sink (input valid, input coefficient, input out_index,
                input last_of_block, output ready);
endinterface

FILE: src/fwht_cell.sv
// One cell of the vector row: holds a word, loads a sample, butterflies with its partner, permutes, shifts.
module fwht_cell (
  input  logic                 clk,
  input  fwht_pkg::cell_ctrl_t ctrl,
  input  logic                 load_sel,
  input  logic                 upper,
  input  fwht_pkg::word_t      sample,
  input  fwht_pkg::word_t      partner,
  input  fwht_pkg::word_t      perm_in,
  input  fwht_pkg::word_t      next_in,
  output fwht_pkg::word_t      word
);
  logic signed [fwht_pkg::WORD_W:0] res;
  logic signed [fwht_pkg::WORD_W:0] adj;
  fwht_pkg::word_t bfly;

  always_comb begin
    if (upper) begin
      res = {word[fwht_pkg::WORD_W-1], word} + {partner[fwht_pkg::WORD_W-1], partner};
    end else begin
      res = {partner[fwht_pkg::WORD_W-1], partner} - {word[fwht_pkg::WORD_W-1], word};
    end
    // truncate toward zero when halving
    adj = res + {{fwht_pkg::WORD_W{1'b0}}, res[fwht_pkg::WORD_W]};
    if (ctrl.inverse) begin
      bfly = adj[fwht_pkg::WORD_W:1];
    end else begin
      bfly = res[fwht_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      fwht_pkg::OP_LOAD:  if (load_sel) word <= sample;
      fwht_pkg::OP_BFLY:  word <= bfly;
      fwht_pkg::OP_PERM:  word <= perm_in;
      fwht_pkg::OP_SHIFT: word <= next_in;
      default:            word <= word;
    endcase
  end
endmodule

FILE: src/fast_walsh_hadamard_transform_unit.sv
// Top level of the Walsh-Hadamard transform unit: control, config port, cell row.
// After the last sample beat the cell row runs the butterfly stages of the effective
//   size_log2, one butterfly stage per cycle; Paley order adds a permute step before emission.
// Blocks do not overlap: new samples are taken only after the last coefficient of a block
//   has been issued; loading and emission each move one beat per cycle unless stalled.
// Reset: synchronous, clears control state and config to size 64, forward, natural.
`include "assert_macros.svh"
module fast_walsh_hadamard_transform_unit (
  input  logic                            clk,
  input  logic                            rst,
  fwht_in_if.sink                         in_ch,
  fwht_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fwht_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  localparam int LW = fwht_pkg::LOG2_MAX_LEN;
  localparam int NL = fwht_pkg::MAX_LEN;

  logic [fwht_pkg::LOG_W-1:0] size_log2;
  logic direction;
  logic output_order;

  fwht_pkg::state_t state;
  logic [fwht_pkg::CNT_W-1:0] load_cnt;
  logic [fwht_pkg::CNT_W-1:0] emit_cnt;
  logic [fwht_pkg::LOG_W-1:0] stage;
  logic [fwht_pkg::LOG_W-1:0] l_lat;
  logic [fwht_pkg::LOG_W-1:0] l_eff;
  logic [fwht_pkg::CNT_W-1:0] n_eff;
  logic [fwht_pkg::CNT_W-1:0] n_lat;
  logic [fwht_pkg::CNT_W-1:0] load_idx;
  logic [fwht_pkg::CNT_W-1:0] load_cnt_next;

  fwht_pkg::cell_ctrl_t ctrl;
  fwht_pkg::word_t words [NL];
  fwht_pkg::word_t partner [NL];
  fwht_pkg::word_t perm_in [NL];
  fwht_pkg::word_t sample_ext;

  logic in_fire;
  logic out_take;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= fwht_pkg::LOG_W'(6);
      direction <= 1'b0;
      output_order <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        fwht_pkg::REG_SIZE_LOG2:    size_log2 <= pwdata[fwht_pkg::LOG_W-1:0];
        fwht_pkg::REG_DIRECTION:    direction <= pwdata[0];
        fwht_pkg::REG_OUTPUT_ORDER: output_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fwht_pkg::REG_SIZE_LOG2:    prdata = {{(32-fwht_pkg::LOG_W){1'b0}}, size_log2};
      fwht_pkg::REG_DIRECTION:    prdata = {31'b0, direction};
      fwht_pkg::REG_OUTPUT_ORDER: prdata = {31'b0, output_order};
      default:                    prdata = 32'b0;
    endcase
  end

  always_comb begin
    if (size_log2 == '0) begin
      l_eff = fwht_pkg::LOG_W'(1);
    end else if (size_log2 > fwht_pkg::LOG_W'(LW)) begin
      l_eff = fwht_pkg::LOG_W'(LW);
    end else begin
      l_eff = size_log2;
    end
    n_eff = fwht_pkg::CNT_W'(1) << l_eff;
    n_lat = fwht_pkg::CNT_W'(1) << l_lat;
    load_idx = (load_cnt >= n_eff) ? '0 : load_cnt;
    load_cnt_next = load_idx + fwht_pkg::CNT_W'(1);
  end

  assign in_ch.ready = (state == fwht_pkg::ST_LOAD);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_take = (state == fwht_pkg::ST_EMIT) && (!out_ch.valid || out_ch.ready);
  assign sample_ext = fwht_pkg::WORD_W'(in_ch.sample_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwht_pkg::ST_LOAD;
      load_cnt <= '0;
      emit_cnt <= '0;
      stage <= '0;
      l_lat <= fwht_pkg::LOG_W'(LW);
    end else begin
      unique case (state)
        fwht_pkg::ST_LOAD: begin
          if (in_fire) begin
            if (load_cnt_next == n_eff) begin
              load_cnt <= '0;
              stage <= '0;
              l_lat <= l_eff;
              state <= fwht_pkg::ST_STAGE;
            end else begin
              load_cnt <= load_cnt_next;
            end
          end
        end
        fwht_pkg::ST_STAGE: begin
          if (stage + fwht_pkg::LOG_W'(1) == l_lat) begin
            emit_cnt <= '0;
            state <= output_order ? fwht_pkg::ST_PERM : fwht_pkg::ST_EMIT;
          end
          stage <= stage + fwht_pkg::LOG_W'(1);
        end
        fwht_pkg::ST_PERM: state <= fwht_pkg::ST_EMIT;
        fwht_pkg::ST_EMIT: begin
          if (out_take) begin
            emit_cnt <= emit_cnt + fwht_pkg::CNT_W'(1);
            if (emit_cnt + fwht_pkg::CNT_W'(1) == n_lat) state <= fwht_pkg::ST_LOAD;
          end
        end
        default: state <= fwht_pkg::ST_LOAD;
      endcase
    end
  end

  always_comb begin
    ctrl.inverse = direction;
    unique case (state)
      fwht_pkg::ST_LOAD:  ctrl.op = in_fire ? fwht_pkg::OP_LOAD : fwht_pkg::OP_HOLD;
      fwht_pkg::ST_STAGE: ctrl.op = fwht_pkg::OP_BFLY;
      fwht_pkg::ST_PERM:  ctrl.op = fwht_pkg::OP_PERM;
      fwht_pkg::ST_EMIT:  ctrl.op = out_take ? fwht_pkg::OP_SHIFT : fwht_pkg::OP_HOLD;
      default:            ctrl.op = fwht_pkg::OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < NL; i++) begin : g_cell
    always_comb begin
      partner[i] = words[i ^ 1];
      for (int s = 1; s < LW; s++) begin
        if (stage == fwht_pkg::LOG_W'(s)) partner[i] = words[i ^ (1 << s)];
      end
      perm_in[i] = words[i];
      for (int l = 1; l <= LW; l++) begin
        if (l_lat == fwht_pkg::LOG_W'(l) && i < (1 << l)) begin
          perm_in[i] = words[fwht_pkg::bit_rev(i, l)];
        end
      end
    end

    fwht_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_sel (load_idx[LW-1:0] == LW'(i)),
      .upper    (((i >> stage) & 1) == 0),
      .sample   (sample_ext),
      .partner  (partner[i]),
      .perm_in  (perm_in[i]),
      .next_in  ((i == NL - 1) ? words[i] : words[(i + 1) % NL]),
      .word     (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_take) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_ch.coefficient <= words[0];
      out_ch.out_index <= emit_cnt[LW-1:0];
      out_ch.last_of_block <= (emit_cnt + fwht_pkg::CNT_W'(1) == n_lat);
    end
  end

  `FWHT_ASSERT(a_out_hold,
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.coefficient)
      && $stable(out_ch.out_index) && $stable(out_ch.last_of_block),
    "output beat changed while stalled")
  `FWHT_ASSERT(a_stage_range,
    state == fwht_pkg::ST_STAGE |-> stage < l_lat,
    "stage count past transform size")
  `FWHT_ASSERT(a_state_onehot, $onehot(state), "state not one-hot")
  `FWHT_ASSERT_ALWAYS(a_pready_high, pready == 1'b1, "pready not high")
endmodule
